// ----- hdl/dnle_pkg.sv -----
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int MAX_LABEL_DEF = 62;
  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 6;
  localparam int NUM_BANK      = 2;

  localparam logic [BYTE_W-1:0] DOT_CODE  = 8'h2E;
  localparam logic [BYTE_W-1:0] TERM_CODE = 8'h00;

  // one finished label, handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic             is_end;
    logic             bank;
  } cmd_t;

  // label buffer write from the front
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [CNT_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } wr_t;

  // bank handed back by the back end
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

// ----- hdl/dnle_front.sv -----
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, fills the label buffer and queues finished labels.
// ----------------------------------------------------------------------------
module dnle_front #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dnle_pkg::BYTE_W-1:0] char_code,
  input  logic                        end_of_name,
  input  logic                        q_full,
  output logic                        q_push,
  output dnle_pkg::cmd_t              q_cmd,
  output dnle_pkg::wr_t               wr,
  input  dnle_pkg::rel_t              rel
);

  logic [dnle_pkg::CNT_W-1:0]    count, count_next;
  logic                          ovf, ovf_next;
  logic                          bank, bank_next;
  logic [dnle_pkg::NUM_BANK-1:0] busy, busy_next;
  logic                          accept;
  logic                          closes;

  assign in_ready = !busy[bank] && !q_full;
  assign accept   = in_valid && in_ready;
  assign closes   = end_of_name || (char_code == dnle_pkg::DOT_CODE);

  always_comb begin
    count_next   = count;
    ovf_next     = ovf;
    bank_next    = bank;
    busy_next    = busy;
    q_push       = 1'b0;
    q_cmd.count  = count;
    q_cmd.ovf    = ovf;
    q_cmd.is_end = end_of_name;
    q_cmd.bank   = bank;
    wr.en        = 1'b0;
    wr.bank      = bank;
    wr.idx       = count;
    wr.data      = char_code;
    if (rel.en) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (closes) begin
        q_push          = 1'b1;
        busy_next[bank] = 1'b1;
        count_next      = '0;
        ovf_next        = 1'b0;
        bank_next       = ~bank;
      end else if (count < dnle_pkg::CNT_W'(MAX_LABEL)) begin
        wr.en      = 1'b1;
        count_next = count + 1'b1;
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      bank  <= 1'b0;
      busy  <= '0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
      bank  <= bank_next;
      busy  <= busy_next;
    end
  end

endmodule

// ----- hdl/dnle_queue.sv -----
// ----------------------------------------------------------------------------
// dnle_queue
// Two-entry queue of finished labels between front and back.
// ----------------------------------------------------------------------------
module dnle_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dnle_pkg::cmd_t push_cmd,
  input  logic           pop,
  output dnle_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  dnle_pkg::cmd_t slot [2];
  logic [1:0]     fill;
  logic           rd_ptr;
  logic           wr_ptr;

  assign head  = slot[rd_ptr];
  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/dnle_back.sv -----
// ----------------------------------------------------------------------------
// dnle_back
// Holds the two-bank label buffer and plays labels out one byte per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module dnle_back #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dnle_pkg::wr_t               wr,
  input  logic                        q_empty,
  input  dnle_pkg::cmd_t              q_head,
  output logic                        q_pop,
  output dnle_pkg::rel_t              rel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dnle_pkg::BYTE_W-1:0] out_byte,
  output logic                        run_last,
  output logic                        name_done,
  output logic                        label_overflow
);

  localparam int DEPTH = dnle_pkg::NUM_BANK * MAX_LABEL;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_LEN, S_CHR, S_TERM} state_t;

  logic [dnle_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [dnle_pkg::BYTE_W-1:0] rd_data;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;

  state_t                      state, state_next;
  dnle_pkg::cmd_t              cur, cur_next;
  logic [dnle_pkg::CNT_W-1:0]  idx, idx_next;
  logic                        can_load;
  logic                        emit;
  logic                        last_chr;
  logic [dnle_pkg::BYTE_W-1:0] e_byte;
  logic                        e_last;
  logic                        e_done;
  logic                        e_ovf;

  assign wr_addr = wr.bank ? (AW'(MAX_LABEL) + AW'(wr.idx)) : AW'(wr.idx);
  assign rd_addr = cur_next.bank ? (AW'(MAX_LABEL) + AW'(idx_next)) : AW'(idx_next);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  assign can_load = !out_valid || out_ready;
  assign last_chr = (idx == dnle_pkg::CNT_W'(cur.count - 1'b1));

  always_comb begin
    state_next = state;
    cur_next   = cur;
    idx_next   = idx;
    q_pop      = 1'b0;
    rel.en     = 1'b0;
    rel.bank   = cur.bank;
    emit       = 1'b0;
    e_byte     = dnle_pkg::TERM_CODE;
    e_last     = 1'b0;
    e_done     = 1'b0;
    e_ovf      = cur.ovf;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cur_next   = q_head;
          idx_next   = '0;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        emit   = 1'b1;
        e_byte = dnle_pkg::BYTE_W'(cur.count);
        e_last = !cur.is_end && (cur.count == '0);
        if (can_load) begin
          if (cur.count != '0) begin
            state_next = S_CHR;
          end else if (cur.is_end) begin
            state_next = S_TERM;
          end else begin
            state_next = S_IDLE;
            rel.en     = 1'b1;
          end
        end
      end
      S_CHR: begin
        emit   = 1'b1;
        e_byte = rd_data;
        e_last = !cur.is_end && last_chr;
        if (can_load) begin
          if (!last_chr) begin
            idx_next = idx + 1'b1;
          end else if (cur.is_end) begin
            state_next = S_TERM;
          end else begin
            state_next = S_IDLE;
            rel.en     = 1'b1;
          end
        end
      end
      S_TERM: begin
        emit   = 1'b1;
        e_last = 1'b1;
        e_done = 1'b1;
        e_ovf  = 1'b0;
        if (can_load) begin
          state_next = S_IDLE;
          rel.en     = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (can_load) begin
        out_valid <= emit;
      end
    end
    cur <= cur_next;
    idx <= idx_next;
    if (can_load && emit) begin
      out_byte       <= e_byte;
      run_last       <= e_last;
      name_done      <= e_done;
      label_overflow <= e_ovf;
    end
  end

endmodule

// ----- hdl/dns_name_label_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit
// Dotted domain name in, DNS wire-format label bytes out.
// ----------------------------------------------------------------------------
// input channel: one character per request (char_code), or an end-of-name
// request (end_of_name = 1). ordinary characters produce nothing; up to
// MAX_LABEL per label are written into one bank of a two-bank label buffer.
// a dot or end-of-name closes the label and queues it for playout.
// output channel: one byte per request: length byte, label characters, and
// after end-of-name the zero terminator. playout runs at one byte per cycle
// from the buffer read port while the receiver does not stall, plus a step
// per label to take it from the queue; a new label is taken only after the
// last byte of the previous one has been loaded for output.
// characters for the next label go into the other bank while a label plays
// out; the front stalls only when both banks still hold labels not yet sent.
// a stalled receiver holds the output register, and the stall backs up
// through the queue to the input.
// reset empties the queue, drops any partial label and clears out_valid; the
// buffer itself is not cleared.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit #(
  parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dnle_pkg::BYTE_W-1:0] char_code,
  input  logic                        end_of_name,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dnle_pkg::BYTE_W-1:0] out_byte,
  output logic                        run_last,
  output logic                        name_done,
  output logic                        label_overflow
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  dnle_pkg::cmd_t q_cmd;
  dnle_pkg::cmd_t q_head;
  dnle_pkg::wr_t  wr;
  dnle_pkg::rel_t rel;

  dnle_front #(
    .MAX_LABEL (MAX_LABEL)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .end_of_name (end_of_name),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .wr          (wr),
    .rel         (rel)
  );

  dnle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  dnle_back #(
    .MAX_LABEL (MAX_LABEL)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .rel            (rel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .name_done      (name_done),
    .label_overflow (label_overflow)
  );

endmodule

// ----- hdl/dnle_checker.sv -----
// ----------------------------------------------------------------------------
// dnle_checker
// Port-level checks of the DNS name label encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dnle_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dnle_pkg::BYTE_W-1:0] out_byte,
  input logic                        run_last,
  input logic                        name_done,
  input logic                        label_overflow
);

  // terminator is a zero byte that ends the run and carries no overflow
  a_term_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && name_done |->
      run_last && (out_byte == dnle_pkg::TERM_CODE) && !label_overflow)
    else $error("terminator byte malformed");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output request withdrawn");

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last))
    else $error("stalled output changed");

endmodule

bind dns_name_label_encoder_unit dnle_checker u_dnle_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .run_last       (run_last),
  .name_done      (name_done),
  .label_overflow (label_overflow)
);
